// ----- rtl/tsac_pkg.sv -----
// Package with shared types and constants for the top source address counter.
`timescale 1ns / 1ps
package tsac_pkg;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned RANK_W  = 5;
    localparam logic [RANK_W-1:0] TOP_COUNT_RESET = 5'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_CMP    = 7'b0000100,
        ST_WRITE  = 7'b0001000,
        ST_SREAD  = 7'b0010000,
        ST_SCMP   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } t_state;
endpackage

// ----- rtl/top_source_address_counter_top.sv -----
// Top level of the top source address counter.
`timescale 1ns / 1ps
// Usage: raise start with i_src_ip and i_end_of_batch while busy is low; the
// transaction is taken at that edge and busy rises in the next cycle. The address
// is searched linearly in the table memory (one registered read port): each used
// slot is read and then compared, the search stops at the first hit, and the hit
// or new slot is written back in the write state; on a miss with a full table no
// slot is written and the overflow flag is set. The next transaction can be taken
// as soon as busy is low again. An item with i_end_of_batch set is counted and
// then reported: for each rank the block scans all used slots once for the next
// entry in order of descending count and ascending slot, then shows one result
// for a single cycle with o_valid high. Ranks are reported one after another,
// each after its own full scan. The receiver cannot stall; results cannot be
// held. busy falls in the cycle that shows the last result, and the table is empty
// again. top_count is written on the cfg channel (i_cfg_valid / o_cfg_ready); it
// is ready whenever the block is idle. Reset clears the fill count, the overflow
// flag and top_count to 10; the memories need no clearing pass.
module top_source_address_counter_top #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned MAX_REPORTED  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tsac_pkg::ADDR_W-1:0] i_src_ip,
    input  logic                        i_end_of_batch,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsac_pkg::RANK_W-1:0] i_cfg_data,
    output logic                        o_valid,
    output logic [tsac_pkg::RANK_W-1:0] o_rank,
    output logic [tsac_pkg::ADDR_W-1:0] o_source_address,
    output logic [tsac_pkg::COUNT_W-1:0] o_packet_count,
    output logic                        o_last_of_run,
    output logic                        o_table_overflow
);
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned K_W   = $clog2(MAX_REPORTED + 1);

    logic [tsac_pkg::ADDR_W-1:0]  m_addr [TABLE_ENTRIES];
    logic [tsac_pkg::COUNT_W-1:0] m_cnt  [TABLE_ENTRIES];

    tsac_pkg::t_state r_state;
    logic [CNT_W-1:0] r_used;
    logic             r_ovf;
    logic [tsac_pkg::RANK_W-1:0] r_top;
    logic [tsac_pkg::ADDR_W-1:0] r_ip;
    logic             r_eob;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [tsac_pkg::ADDR_W-1:0]  r_rd_addr;
    logic [tsac_pkg::COUNT_W-1:0] r_rd_cnt;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [tsac_pkg::COUNT_W-1:0] r_hit_cnt;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   r_n;
    logic             r_have;
    logic [IDX_W-1:0] r_best;
    logic [tsac_pkg::ADDR_W-1:0]  r_best_addr;
    logic [tsac_pkg::COUNT_W-1:0] r_best_cnt;
    logic [IDX_W-1:0] r_prev_idx;
    logic [tsac_pkg::COUNT_W-1:0] r_prev_cnt;

    logic             w_en;
    logic [IDX_W-1:0] w_idx;
    logic [tsac_pkg::ADDR_W-1:0]  w_addr;
    logic [tsac_pkg::COUNT_W-1:0] w_cnt;
    logic [K_W-1:0]   want;
    logic [K_W-1:0]   n_n;
    logic             eligible;

    assign busy        = (r_state != tsac_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == tsac_pkg::ST_IDLE);

    // Clamp top_count to 1..MAX_REPORTED and to the number of used slots.
    always_comb begin
        if (r_top == '0) begin
            want = K_W'(1);
        end else if (32'(r_top) > MAX_REPORTED) begin
            want = K_W'(MAX_REPORTED);
        end else begin
            want = K_W'(r_top);
        end
        if (32'(want) > 32'(r_used)) begin
            n_n = K_W'(r_used);
        end else begin
            n_n = want;
        end
    end

    // A slot is still to be reported when it comes after the last reported one
    // in order of descending count, then ascending slot.
    assign eligible = (r_k == '0) || (r_rd_cnt < r_prev_cnt) ||
                      ((r_rd_cnt == r_prev_cnt) && (r_idx[IDX_W-1:0] > r_prev_idx));

    // Memory: one write, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_addr[w_idx] <= w_addr;
            m_cnt[w_idx]  <= w_cnt;
        end
        r_rd_addr <= m_addr[r_rd_idx];
        r_rd_cnt  <= m_cnt[r_rd_idx];
    end

    always_comb begin
        w_en   = (r_state == tsac_pkg::ST_WRITE) && (r_hit || (32'(r_used) < TABLE_ENTRIES));
        w_idx  = r_hit ? r_hit_idx : r_used[IDX_W-1:0];
        w_addr = r_ip;
        w_cnt  = r_hit ? ((r_hit_cnt == tsac_pkg::COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1)
                       : tsac_pkg::COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsac_pkg::ST_IDLE;
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_top   <= tsac_pkg::TOP_COUNT_RESET;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                tsac_pkg::ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_top <= i_cfg_data;
                    end
                    if (start) begin
                        r_ip     <= i_src_ip;
                        r_eob    <= i_end_of_batch;
                        r_idx    <= '0;
                        r_rd_idx <= '0;
                        r_hit    <= 1'b0;
                        r_state  <= tsac_pkg::ST_READ;
                    end
                end
                tsac_pkg::ST_READ: begin
                    // The slot address issued last cycle is now on the read port.
                    if (r_idx >= r_used || r_hit) begin
                        r_state <= tsac_pkg::ST_WRITE;
                    end else begin
                        r_state <= tsac_pkg::ST_CMP;
                    end
                end
                tsac_pkg::ST_CMP: begin
                    if (r_rd_addr == r_ip) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx[IDX_W-1:0];
                        r_hit_cnt <= r_rd_cnt;
                        r_state   <= tsac_pkg::ST_WRITE;
                    end else if (r_idx + 1'b1 >= r_used) begin
                        r_state <= tsac_pkg::ST_WRITE;
                    end else begin
                        r_idx    <= r_idx + 1'b1;
                        r_rd_idx <= IDX_W'(r_idx + 1'b1);
                        r_state  <= tsac_pkg::ST_READ;
                    end
                end
                tsac_pkg::ST_WRITE: begin
                    if (!r_hit) begin
                        if (32'(r_used) < TABLE_ENTRIES) begin
                            r_used <= r_used + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (r_eob) begin
                        r_k      <= '0;
                        r_state  <= tsac_pkg::ST_SREAD;
                        r_idx    <= '0;
                        r_rd_idx <= '0;
                        r_have   <= 1'b0;
                    end else begin
                        r_state <= tsac_pkg::ST_IDLE;
                    end
                end
                tsac_pkg::ST_SREAD: begin
                    r_n     <= n_n;
                    r_state <= tsac_pkg::ST_SCMP;
                end
                tsac_pkg::ST_SCMP: begin
                    // Strict greater keeps the earliest slot on a tie.
                    if (eligible && (!r_have || r_rd_cnt > r_best_cnt)) begin
                        r_have      <= 1'b1;
                        r_best      <= r_idx[IDX_W-1:0];
                        r_best_addr <= r_rd_addr;
                        r_best_cnt  <= r_rd_cnt;
                    end
                    if (r_idx + 1'b1 >= r_used) begin
                        r_state <= tsac_pkg::ST_EMIT;
                    end else begin
                        r_idx    <= r_idx + 1'b1;
                        r_rd_idx <= IDX_W'(r_idx + 1'b1);
                        r_state  <= tsac_pkg::ST_SREAD;
                    end
                end
                tsac_pkg::ST_EMIT: begin
                    o_valid          <= 1'b1;
                    o_rank           <= tsac_pkg::RANK_W'(r_k + 1'b1);
                    o_source_address <= r_best_addr;
                    o_packet_count   <= r_best_cnt;
                    o_last_of_run    <= (r_k + 1'b1 == r_n);
                    o_table_overflow <= r_ovf;
                    r_prev_idx       <= r_best;
                    r_prev_cnt       <= r_best_cnt;
                    r_k              <= r_k + 1'b1;
                    r_idx            <= '0;
                    r_rd_idx         <= '0;
                    r_have           <= 1'b0;
                    if (r_k + 1'b1 == r_n) begin
                        r_used  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= tsac_pkg::ST_IDLE;
                    end else begin
                        r_state <= tsac_pkg::ST_SREAD;
                    end
                end
                default: r_state <= tsac_pkg::ST_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= TABLE_ENTRIES) else $error("fill count above capacity");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run |-> r_state == tsac_pkg::ST_IDLE && r_used == '0)
        else $error("table not cleared after report");
    a_emit_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tsac_pkg::ST_EMIT |-> r_have) else $error("emit without candidate");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> busy) else $error("report ended early");
endmodule
